[src/sfir_pkg.sv]
package sfir_pkg;

  // Sample, tap and register widths
  localparam int SAMPLE_W     = 16;
  localparam int TAP_W        = 24;
  localparam int TARGET_W     = 16;
  localparam int GAIN_W       = 16;
  localparam int TAP_COUNT_W  = 9;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // Fixed-point positions
  localparam int GAIN_FRAC    = 13;
  localparam int TAP_FRAC     = 20;
  localparam int TARGET_SHIFT = 5;

  // Register reset values
  localparam logic [GAIN_W-1:0]      GAIN_RESET      = 16'd8192;
  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 9'd256;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_GAIN      = 1'b0;
  localparam logic REG_TAP_COUNT = 1'b1;

  // Item commands
  localparam logic CMD_AUDIO = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  // Tap channels
  localparam int CH_LEFT  = 0;
  localparam int CH_RIGHT = 1;

  // One channel's tap state
  typedef struct packed {
    logic signed [TARGET_W-1:0] target;
    logic signed [TAP_W-1:0]    current;
    logic signed [TAP_W-1:0]    step;
  } tap_entry_t;

  // One tap memory word: both channels at the same tap index
  typedef tap_entry_t [1:0] tap_row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_READ,
    ST_LD_WRITE,
    ST_MONO,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

[src/sfir_if.sv]
interface sfir_item_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;
  logic               channel;
  logic [7:0]         tap_index;
  logic signed [15:0] tap_value;

  modport source (
    output valid, command, left_in, right_in, channel, tap_index, tap_value,
    input  ready
  );
  modport sink (
    input  valid, command, left_in, right_in, channel, tap_index, tap_value,
    output ready
  );
endinterface

interface sfir_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (
    output valid, left_out, right_out,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out,
    output ready
  );
endinterface

[src/sfir_tap_ramp.sv]
module sfir_tap_ramp #(
  parameter int HOP_LOG2 = 5
) (
  input  logic signed [sfir_pkg::TARGET_W-1:0] target,
  input  logic signed [sfir_pkg::TAP_W-1:0]    current,
  input  logic signed [sfir_pkg::TAP_W-1:0]    step,
  input  logic                                 hop_wrap,
  output logic signed [sfir_pkg::TAP_W-1:0]    step_next,
  output logic signed [sfir_pkg::TAP_W-1:0]    current_next
);
  import sfir_pkg::*;

  localparam int DIFF_W = TAP_W + 2;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_sh;

  // Recompute the step toward the scaled target at a hop boundary
  always_comb begin
    diff      = (DIFF_W'(target) <<< TARGET_SHIFT) - DIFF_W'(current);
    diff_sh   = diff >>> HOP_LOG2;
    step_next = hop_wrap ? diff_sh[TAP_W-1:0] : step;
  end

  // Advance the tap by one step, wrapping at the tap width
  assign current_next = current + step_next;

endmodule

[src/stereo_fir_with_tap_ramping.sv]
// Stereo FIR with linear tap ramping. An audio beat (command 0) sums left and right,
// scales by gain (Q3.13), saturates to Q1.15 and writes the sample into a delay ring
// shared by both channels; the ring is then convolved with the left and right current
// taps (Q1.20) over tap_count taps, clamped to MAX_TAPS, and one saturated stereo result
// beat follows. Every 2^HOP_LOG2 audio beats each tap's step is reloaded as
// (target*32 - current) >> HOP_LOG2, and every audio beat adds the step to its tap, so
// taps glide toward their targets. A load beat (command 1) writes one target tap and
// gives no result; indexes at or above MAX_TAPS are dropped. An audio beat occupies the
// block for one sweep over the tap memory, with its one read and one write port, which
// reads, ramps and writes back one tap row per cycle for all MAX_TAPS taps; a load beat
// occupies it for one read and one write of a tap row. The next beat is accepted in the
// cycle after a beat finishes; a finished result waits in the output register while the
// next beat is taken, and a frame that finishes while an earlier result still waits
// holds in its last cycle until that result is taken. After reset the block clears every
// entry of both memories before taking the first beat.
// Registers (APB, 32-bit): gain at 0x0, tap_count at 0x4.
module stereo_fir_with_tap_ramping #(
  parameter int MAX_TAPS    = 256,
  parameter int DELAY_DEPTH = 256,
  parameter int HOP_LOG2    = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  sfir_item_if.sink                        items,
  sfir_result_if.source                    results,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfir_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sfir_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sfir_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import sfir_pkg::*;

  localparam int TAP_AW    = $clog2(MAX_TAPS);
  localparam int RING_AW   = $clog2(DELAY_DEPTH);
  localparam int CLR_DEPTH = (MAX_TAPS > DELAY_DEPTH) ? MAX_TAPS : DELAY_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int HOP_W     = (HOP_LOG2 > 0) ? HOP_LOG2 : 1;
  localparam int HOP_LAST  = (1 << HOP_LOG2) - 1;
  localparam int SUM_W     = SAMPLE_W + 1;
  localparam int MONO_W    = 2 * SUM_W;
  localparam int PROD_W    = TAP_W + SAMPLE_W;
  localparam int ACC_W     = PROD_W + TAP_AW + 1;

  // Configuration registers
  logic [GAIN_W-1:0]      gain;
  logic [TAP_COUNT_W-1:0] tap_count;

  // Control state
  state_t             state;
  state_t             state_next;
  logic [CLR_W-1:0]   clr;
  logic [TAP_AW-1:0]  k;
  logic [RING_AW-1:0] wp;
  logic [HOP_W-1:0]   hop_count;
  logic               s1_valid;
  logic               s2_valid;
  logic               res_valid;

  // Payload registers
  logic [RING_AW-1:0]        rp;
  logic                      hop_wrap;
  logic signed [MONO_W-1:0]  mono_prod;
  logic                      ld_ch;
  logic [TAP_AW-1:0]         ld_idx;
  logic                      ld_ok;
  logic signed [TARGET_W-1:0] ld_val;
  logic [TAP_AW-1:0]         s1_k;
  logic                      s1_mac;
  logic                      s2_mac;
  logic signed [PROD_W-1:0]  prod_l;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_l;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SAMPLE_W-1:0] res_left;
  logic signed [SAMPLE_W-1:0] res_right;

  // Memories
  tap_row_t                   tap_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] ring_mem [DELAY_DEPTH];
  tap_row_t                   tap_rd;
  logic signed [SAMPLE_W-1:0] ring_rd;

  // Control strobes
  logic clear_en;
  logic mono_en;
  logic issue_en;
  logic ld_write_en;
  logic finish_en;
  logic accept;

  // Memory port signals
  logic                       tap_we;
  logic [TAP_AW-1:0]          tap_waddr;
  logic [TAP_AW-1:0]          tap_raddr;
  tap_row_t                   tap_wdata;
  tap_row_t                   ld_row;
  tap_row_t                   upd_row;
  logic                       ring_we;
  logic [RING_AW-1:0]         ring_waddr;
  logic signed [SAMPLE_W-1:0] ring_wdata;

  logic signed [MONO_W-1:0]   mono_sh;
  logic signed [SAMPLE_W-1:0] mono_sat;
  logic signed [SUM_W-1:0]    in_sum;
  logic signed [TAP_W-1:0]    step_n [2];
  logic signed [TAP_W-1:0]    cur_n [2];

  // Shift an accumulator down to Q1.15 and saturate
  function automatic logic signed [SAMPLE_W-1:0] sat_acc(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sh;
    logic                    pos_ovf;
    logic                    neg_ovf;
    sh      = a >>> TAP_FRAC;
    pos_ovf = !sh[ACC_W-1] && (|sh[ACC_W-2:SAMPLE_W-1]);
    neg_ovf = sh[ACC_W-1] && !(&sh[ACC_W-2:SAMPLE_W-1]);
    if (pos_ovf) begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (neg_ovf) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return sh[SAMPLE_W-1:0];
  endfunction

  // APB register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RESET;
      tap_count <= TAP_COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_GAIN:      gain      <= pwdata[GAIN_W-1:0];
        REG_TAP_COUNT: tap_count <= pwdata[TAP_COUNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GAIN:      prdata = APB_DATA_W'(gain);
      REG_TAP_COUNT: prdata = APB_DATA_W'(tap_count);
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == CLR_W'(CLR_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (items.valid) begin
          state_next = (items.command == CMD_LOAD) ? ST_LD_READ : ST_MONO;
        end
      end
      ST_LD_READ:  state_next = ST_LD_WRITE;
      ST_LD_WRITE: state_next = ST_IDLE;
      ST_MONO:     state_next = ST_RUN;
      ST_RUN: begin
        if (k == TAP_AW'(MAX_TAPS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || results.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    clear_en    = (state == ST_CLEAR);
    items.ready = (state == ST_IDLE);
    mono_en     = (state == ST_MONO);
    issue_en    = (state == ST_RUN);
    ld_write_en = (state == ST_LD_WRITE);
    finish_en   = (state == ST_DONE) && (!res_valid || results.ready);
    tap_raddr   = issue_en ? k : ld_idx;
  end

  assign accept = items.valid && items.ready;

  // Mono sample: saturate the scaled sum
  always_comb begin
    mono_sh  = mono_prod >>> GAIN_FRAC;
    mono_sat = mono_sh[SAMPLE_W-1:0];
    if (!mono_sh[MONO_W-1] && (|mono_sh[MONO_W-2:SAMPLE_W-1])) begin
      mono_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (mono_sh[MONO_W-1] && !(&mono_sh[MONO_W-2:SAMPLE_W-1])) begin
      mono_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
  end

  assign in_sum = SUM_W'(items.left_in) + SUM_W'(items.right_in);

  // Ramp both channels of the row coming out of the tap memory
  for (genvar c = 0; c < 2; c++) begin : g_ramp
    sfir_tap_ramp #(
      .HOP_LOG2 (HOP_LOG2)
    ) u_ramp (
      .target       (tap_rd[c].target),
      .current      (tap_rd[c].current),
      .step         (tap_rd[c].step),
      .hop_wrap     (hop_wrap),
      .step_next    (step_n[c]),
      .current_next (cur_n[c])
    );
  end

  always_comb begin
    upd_row = tap_rd;
    for (int c = 0; c < 2; c++) begin
      upd_row[c].step    = step_n[c];
      upd_row[c].current = cur_n[c];
    end
    ld_row = tap_rd;
    ld_row[ld_ch].target = ld_val;
  end

  // Memory write selection
  always_comb begin
    tap_we     = 1'b0;
    tap_waddr  = s1_k;
    tap_wdata  = upd_row;
    ring_we    = mono_en;
    ring_waddr = wp;
    ring_wdata = mono_sat;
    if (clear_en) begin
      tap_we     = (32'(clr) < MAX_TAPS);
      tap_waddr  = TAP_AW'(clr);
      tap_wdata  = '0;
      ring_we    = (32'(clr) < DELAY_DEPTH);
      ring_waddr = RING_AW'(clr);
      ring_wdata = '0;
    end else if (ld_write_en) begin
      tap_we    = ld_ok;
      tap_waddr = ld_idx;
      tap_wdata = ld_row;
    end else if (s1_valid) begin
      tap_we = 1'b1;
    end
  end

  // Tap memory
  always_ff @(posedge clk) begin
    if (tap_we) tap_mem[tap_waddr] <= tap_wdata;
    tap_rd <= tap_mem[tap_raddr];
  end

  // Delay ring memory
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    ring_rd <= ring_mem[rp];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      k         <= '0;
      wp        <= '0;
      hop_count <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue_en;
      s2_valid <= s1_valid;
      // advance the clearing sweep
      if (clear_en) clr <= clr + 1'b1;
      // walk the tap index over every tap
      if (mono_en) begin
        k <= '0;
      end else if (issue_en) begin
        k <= k + 1'b1;
      end
      // close the frame: advance ring and hop counter
      if (finish_en) begin
        wp        <= (wp == RING_AW'(DELAY_DEPTH - 1)) ? '0 : wp + 1'b1;
        hop_count <= hop_wrap ? '0 : hop_count + 1'b1;
      end
      // hold the result until it is taken
      if (finish_en) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // latch the beat
    if (accept) begin
      ld_ch     <= items.channel;
      ld_idx    <= TAP_AW'(items.tap_index);
      ld_ok     <= (32'(items.tap_index) < MAX_TAPS);
      ld_val    <= items.tap_value;
      mono_prod <= MONO_W'(in_sum) * MONO_W'($signed({1'b0, gain}));
      hop_wrap  <= (hop_count == HOP_W'(HOP_LAST));
    end
    // step the ring read pointer backward from the newest sample
    if (mono_en) begin
      rp <= wp;
    end else if (issue_en) begin
      rp <= (rp == '0) ? RING_AW'(DELAY_DEPTH - 1) : rp - 1'b1;
    end
    if (issue_en) begin
      s1_k   <= k;
      s1_mac <= (32'(k) < 32'(tap_count));
    end
    // multiply stage
    prod_l <= PROD_W'(tap_rd[CH_LEFT].current) * PROD_W'(ring_rd);
    prod_r <= PROD_W'(tap_rd[CH_RIGHT].current) * PROD_W'(ring_rd);
    s2_mac <= s1_mac;
    // accumulate stage
    if (mono_en) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (s2_valid && s2_mac) begin
      acc_l <= acc_l + {{(ACC_W-PROD_W){prod_l[PROD_W-1]}}, prod_l};
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
    // output register
    if (finish_en) begin
      res_left  <= sat_acc(acc_l);
      res_right <= sat_acc(acc_r);
    end
  end

  assign results.valid     = res_valid;
  assign results.left_out  = res_left;
  assign results.right_out = res_right;

  // A result beat appears only at the end of a frame
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside frame completion");

  // No beat is taken while the tap pipeline still holds work
  assert property (@(posedge clk) disable iff (rst)
    items.ready |-> (!s1_valid && !s2_valid))
    else $error("beat accepted with tap pipeline busy");

  // Write-back never lands on the row being read in the sweep
  assert property (@(posedge clk) disable iff (rst)
    (tap_we && issue_en) |-> (tap_waddr != k))
    else $error("tap write-back collides with sweep read");

endmodule
